FILE: hdl/tam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tam_pkg
// Shared types and constants of the tremolo amplitude modulator: widths,
// sine table geometry, polynomial coefficients, register map and states.
// ----------------------------------------------------------------------------
package tam_pkg;

	// sine table and phase accumulator geometry
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_WIDTH     = 32;
	localparam int SINE_N          = 1 << SINE_TABLE_BITS;
	localparam int SINE_W          = 15;

	// datapath widths
	localparam int SAMPLE_W = 32;
	localparam int DEPTH_W  = 16;
	localparam int GAIN_W   = 17;
	localparam int MUL_W    = 33;
	localparam int PROD_W   = 64;
	localparam int U_W      = 30;
	localparam int POLY_W   = 32;

	// register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd2;

	localparam logic [31:0]        PHASE_INC_RST = 32'd447392;
	localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST = 16'd32768;

	// odd Taylor series of sin(pi/2 * u), magnitudes in Q30
	localparam logic [POLY_W-1:0] COEF_A11   = 32'd3864;
	localparam int                POLY_TERMS = 5;
	localparam logic [2:0]        POLY_LAST  = 3'(POLY_TERMS - 1);
	localparam logic [POLY_W-1:0] POLY_COEF [POLY_TERMS] = '{
		32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
	};

	localparam logic [SINE_W-1:0] SINE_MAX = 15'd32767;

	typedef enum logic [3:0] {
		ST_INIT_UU,
		ST_INIT_T,
		ST_INIT_PM,
		ST_INIT_PS,
		ST_INIT_VM,
		ST_INIT_WR,
		ST_IDLE,
		ST_TERM,
		ST_GAIN,
		ST_YMUL,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/tremolo_amplitude_modulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tremolo_amplitude_modulator
// Sine LFO tremolo: scales each sample by 1 + depth * sin(phase) when enabled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, sample_in) takes one signed sample per
//   transaction; output channel (out_valid / out_stall, sample_out, clipped)
//   returns one result per sample, in order. The config channel
//   (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready; write it
//   only while no sample is in flight.
//   After reset the sine quarter table is computed into RAM with the shared
//   multiplier, entry by entry, with in_stall high.
//   Enabled: the sample passes through states TERM, GAIN, YMUL and DONE, with
//   two passes through the shared 33x33 multiplier plus the registered table
//   read; no new sample is taken until the block is back in IDLE.
//   Pass-through: IDLE to DONE to the output register, again one sample at a time.
//   A finished result sits in the output register while out_stall is high;
//   the block still takes the next sample and holds its result until the
//   register frees up. The LFO phase advances on every input transaction.
// ----------------------------------------------------------------------------
module tremolo_amplitude_modulator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [tam_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [tam_pkg::SAMPLE_W-1:0]       sample_out,
	output logic                                      clipped,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [tam_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [tam_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int TB = tam_pkg::SINE_TABLE_BITS;
	localparam int PW = tam_pkg::PHASE_WIDTH;
	localparam int SW = tam_pkg::SAMPLE_W;
	localparam int QW = tam_pkg::PROD_W;
	localparam int MW = tam_pkg::MUL_W;
	localparam logic [TB-1:0] K_LAST = TB'(tam_pkg::SINE_N - 1);
	localparam logic signed [QW-1:0] TERM_BIAS = QW'(65535);
	localparam logic signed [QW-1:0] Y_BIAS    = QW'(32767);
	localparam logic signed [QW-1:0] GAIN_ONE  = QW'(32768);
	localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};

	tam_pkg::state_t state_q, state_d;

	// configuration registers
	logic [31:0]                   phase_inc_q;
	logic [tam_pkg::DEPTH_W-1:0]   depth_q;
	logic                          enable_q;

	logic [PW-1:0]                 lfo_phase_q;
	logic [PW-1:0]                 inc_ext;
	logic [PW+31:0]                inc_wide;
	logic [PW-1:0]                 phase_next;

	// table build sequencer
	logic [TB-1:0]                 k_q;
	logic [2:0]                    j_q;
	logic [tam_pkg::POLY_W-1:0]    p_q;
	logic [tam_pkg::POLY_W-1:0]    t_q;
	logic [tam_pkg::U_W-1:0]       u;
	logic [tam_pkg::POLY_W-1:0]    prod_q30;
	logic [tam_pkg::POLY_W:0]      v_round;
	logic [tam_pkg::POLY_W-15:0]   v_q15;
	logic [tam_pkg::SINE_W-1:0]    rom_wdata;

	// shared multiplier
	logic signed [MW-1:0]          mul_a, mul_b;
	logic signed [2*MW-1:0]        mul_full;
	logic                          mul_en;
	logic signed [QW-1:0]          prod_q;

	// sample path
	logic signed [SW-1:0]          x_q;
	logic                          pass_q;
	logic [1:0]                    quad_q;
	logic                          idx_zero_q;
	logic [1:0]                    quad;
	logic [TB-1:0]                 idx;
	logic [TB-1:0]                 rom_raddr;
	logic [tam_pkg::SINE_W-1:0]    rom_rdata;
	logic                          rom_we;
	logic [tam_pkg::SINE_W-1:0]    sine_mag;
	logic signed [15:0]            sine_val;
	logic [tam_pkg::GAIN_W-1:0]    gain_q;
	logic signed [QW-1:0]          term_full;
	logic signed [QW-1:0]          gain_sum;
	logic signed [QW-1:0]          y_full;
	logic                          y_ovf;
	logic signed [SW-1:0]          y_sat;
	logic                          in_accept;
	logic                          out_free;

	logic                          out_valid_q;
	logic signed [SW-1:0]          out_sample_q;
	logic                          out_clip_q;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// phase step sized to the accumulator, added modulo its width
	assign inc_wide   = {{PW{1'b0}}, phase_inc_q};
	assign inc_ext    = inc_wide[PW-1:0];
	assign phase_next = lfo_phase_q + inc_ext;

	// quadrant and table index from the phase before this sample's step
	assign quad      = lfo_phase_q[PW-1 -: 2];
	assign idx       = lfo_phase_q[PW-3 -: TB];
	assign rom_raddr = quad[0] ? (TB'(0) - idx) : idx;

	// table build arithmetic
	assign u         = tam_pkg::U_W'(k_q) << (tam_pkg::U_W - TB);
	assign prod_q30  = prod_q[30 +: tam_pkg::POLY_W];
	assign v_round   = {1'b0, prod_q30} + (tam_pkg::POLY_W + 1)'(16384);
	assign v_q15     = v_round[tam_pkg::POLY_W:15];
	assign rom_wdata = (v_q15 > {{(tam_pkg::POLY_W - 14 - tam_pkg::SINE_W){1'b0}},
		tam_pkg::SINE_MAX}) ? tam_pkg::SINE_MAX : v_q15[tam_pkg::SINE_W-1:0];

	// signed sine value
	assign sine_mag = (quad_q[0] && idx_zero_q) ? tam_pkg::SINE_MAX : rom_rdata;
	assign sine_val = quad_q[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

	// division by powers of two, truncating toward zero
	assign term_full = prod_q[QW-1] ? ((prod_q + TERM_BIAS) >>> 16) : (prod_q >>> 16);
	assign gain_sum  = term_full + GAIN_ONE;
	assign y_full    = prod_q[QW-1] ? ((prod_q + Y_BIAS) >>> 15) : (prod_q >>> 15);

	// saturation to the sample range
	assign y_ovf = !((&y_full[QW-1:SW-1]) || !(|y_full[QW-1:SW-1]));
	assign y_sat = y_ovf ? (y_full[QW-1] ? Y_MIN : Y_MAX) : y_full[SW-1:0];

	assign mul_full = mul_a * mul_b;

	tam_ram #(
		.WIDTH (tam_pkg::SINE_W),
		.DEPTH (tam_pkg::SINE_N)
	) u_sine_ram (
		.clk   (clk),
		.we    (rom_we),
		.waddr (k_q),
		.wdata (rom_wdata),
		.raddr (rom_raddr),
		.rdata (rom_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tam_pkg::ST_INIT_UU;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, multiplier operand select, table write and input stall
	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		mul_en   = 1'b0;
		rom_we   = 1'b0;
		in_stall = 1'b1;
		unique case (state_q)
			tam_pkg::ST_INIT_UU: begin
				mul_a   = {3'b000, u};
				mul_b   = {3'b000, u};
				mul_en  = 1'b1;
				state_d = tam_pkg::ST_INIT_T;
			end
			tam_pkg::ST_INIT_T: begin
				state_d = tam_pkg::ST_INIT_PM;
			end
			tam_pkg::ST_INIT_PM: begin
				mul_a   = {1'b0, p_q};
				mul_b   = {1'b0, t_q};
				mul_en  = 1'b1;
				state_d = tam_pkg::ST_INIT_PS;
			end
			tam_pkg::ST_INIT_PS: begin
				state_d = (j_q == tam_pkg::POLY_LAST) ? tam_pkg::ST_INIT_VM
					: tam_pkg::ST_INIT_PM;
			end
			tam_pkg::ST_INIT_VM: begin
				mul_a   = {1'b0, p_q};
				mul_b   = {3'b000, u};
				mul_en  = 1'b1;
				state_d = tam_pkg::ST_INIT_WR;
			end
			tam_pkg::ST_INIT_WR: begin
				rom_we  = 1'b1;
				state_d = (k_q == K_LAST) ? tam_pkg::ST_IDLE : tam_pkg::ST_INIT_UU;
			end
			tam_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = enable_q ? tam_pkg::ST_TERM : tam_pkg::ST_DONE;
				end
			end
			tam_pkg::ST_TERM: begin
				mul_a   = {{(MW-tam_pkg::DEPTH_W){1'b0}}, depth_q};
				mul_b   = {{(MW-16){sine_val[15]}}, sine_val};
				mul_en  = 1'b1;
				state_d = tam_pkg::ST_GAIN;
			end
			tam_pkg::ST_GAIN: begin
				state_d = tam_pkg::ST_YMUL;
			end
			tam_pkg::ST_YMUL: begin
				mul_a   = {{(MW-SW){x_q[SW-1]}}, x_q};
				mul_b   = {{(MW-tam_pkg::GAIN_W){1'b0}}, gain_q};
				mul_en  = 1'b1;
				state_d = tam_pkg::ST_DONE;
			end
			tam_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = tam_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tam_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration writes, index beyond the map is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= tam_pkg::PHASE_INC_RST;
			depth_q     <= tam_pkg::MOD_DEPTH_RST;
			enable_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tam_pkg::REG_PHASE_INC: phase_inc_q <= cfg_data;
				tam_pkg::REG_MOD_DEPTH: depth_q     <= cfg_data[tam_pkg::DEPTH_W-1:0];
				tam_pkg::REG_ENABLE:    enable_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// control counters, phase accumulator and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			j_q         <= '0;
			lfo_phase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == tam_pkg::ST_INIT_WR) begin
				k_q <= k_q + TB'(1);
			end
			if (state_q == tam_pkg::ST_INIT_PS) begin
				j_q <= (j_q == tam_pkg::POLY_LAST) ? 3'd0 : j_q + 3'd1;
			end
			if (in_accept) begin
				lfo_phase_q <= phase_next;
			end
			if (state_q == tam_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_full[QW-1:0];
		end
		if (state_q == tam_pkg::ST_INIT_T) begin
			t_q <= prod_q30;
			p_q <= tam_pkg::COEF_A11;
		end
		if (state_q == tam_pkg::ST_INIT_PS) begin
			p_q <= tam_pkg::POLY_COEF[j_q] - prod_q30;
		end
		if (in_accept) begin
			x_q        <= sample_in;
			pass_q     <= !enable_q;
			quad_q     <= quad;
			idx_zero_q <= (idx == TB'(0));
		end
		if (state_q == tam_pkg::ST_GAIN) begin
			gain_q <= gain_sum[tam_pkg::GAIN_W-1:0];
		end
		if (state_q == tam_pkg::ST_DONE && out_free) begin
			out_sample_q <= pass_q ? x_q : y_sat;
			out_clip_q   <= !pass_q && y_ovf;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_sample_q;
	assign clipped    = out_clip_q;

`ifndef SYNTHESIS
	// the phase steps by the increment on each input transaction
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> lfo_phase_q == $past(phase_next))
		else $error("lfo phase did not advance by the increment");

	// a sample in flight keeps the input side stalled
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("input taken while previous sample still in flight");

	// a clipped result sits at a range bound
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (sample_out == Y_MAX) || (sample_out == Y_MIN))
		else $error("clipped result not at a saturation bound");
`endif

endmodule
`default_nettype wire

FILE: hdl/tam_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tam_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tam_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: tb/tb_tremolo_amplitude_modulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tremolo_amplitude_modulator
// Self-checking bench for the sine LFO tremolo. A clocked driver feeds
// samples from a queue. A clocked monitor checks every result against a
// bit-exact fixed-point model of the gain path, which has its own sine table,
// phase accumulator and register copy. Both sides idle in random bursts, and
// once the output holds off long enough to back the block up. The registers
// are rewritten between phases of traffic, extremes included.
// ----------------------------------------------------------------------------
module tb_tremolo_amplitude_modulator;

	localparam int SINE_TABLE_BITS = tam_pkg::SINE_TABLE_BITS;
	localparam int PHASE_WIDTH     = tam_pkg::PHASE_WIDTH;
	localparam int SINE_N          = tam_pkg::SINE_N;
	localparam int SAMPLE_W        = tam_pkg::SAMPLE_W;
	localparam int DEPTH_W         = tam_pkg::DEPTH_W;
	localparam int CFG_IDX_W       = tam_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W      = tam_pkg::CFG_DATA_W;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 1830;
	localparam int SETTLE_CYCLES  = 12;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int MAX_PRINTED    = 100;
	localparam int IDX_SHIFT      = PHASE_WIDTH - SINE_TABLE_BITS - 2;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// sin(pi/2 * u) series magnitudes, Q30
	localparam longint unsigned K1  = 64'd1686629713;
	localparam longint unsigned K3  = 64'd693598668;
	localparam longint unsigned K5  = 64'd85569306;
	localparam longint unsigned K7  = 64'd5026995;
	localparam longint unsigned K9  = 64'd172272;
	localparam longint unsigned K11 = 64'd3864;

	localparam longint SAT_MAX = 64'sh7FFF_FFFF;
	localparam longint SAT_MIN = -64'sh8000_0000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clip;
	} tremolo_result_t;

	// dut signals
	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       in_valid   = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in  = '0;
	logic                       out_valid;
	logic                       out_stall  = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       clipped;
	logic                       cfg_valid  = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index  = '0;
	logic [CFG_DATA_W-1:0]      cfg_data   = '0;

	// model state
	logic [15:0]            sine_quarter [SINE_N];
	logic [31:0]            cur_phase_inc;
	logic [DEPTH_W-1:0]     cur_depth;
	logic                   cur_enable;
	logic [PHASE_WIDTH-1:0] lfo_phase;

	logic signed [SAMPLE_W-1:0] pending_samples [$];
	tremolo_result_t            expected_results [$];

	int  items_issued = 0;
	int  items_taken  = 0;
	int  items_pushed = 0;
	int  error_count  = 0;
	int  send_gap     = 0;
	int  stall_gap    = 0;
	int  hold_left    = 0;
	int  quiet_cycles = 0;
	bit  hold_request = 1'b0;
	bit  hold_done    = 1'b0;
	bit  calm         = 1'b0;
	logic            next_stall;
	tremolo_result_t want;

	tremolo_amplitude_modulator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.clipped   (clipped),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// quarter-wave sine in Q1.15 from the nested odd polynomial
	function automatic void build_sine_quarter();
		longint unsigned u, t, p, v;
		int k;
		for (k = 0; k < SINE_N; k++) begin
			u = k;
			u = u << (30 - SINE_TABLE_BITS);
			t = (u * u) >> 30;
			p = K11;
			p = K9 - ((p * t) >> 30);
			p = K7 - ((p * t) >> 30);
			p = K5 - ((p * t) >> 30);
			p = K3 - ((p * t) >> 30);
			p = K1 - ((p * t) >> 30);
			v = (p * u) >> 30;
			v = (v + 64'd16384) >> 15;
			if (v > 64'd32767)
				v = 64'd32767;
			sine_quarter[k] = v[15:0];
		end
	endfunction

	// four-quadrant sine from the top phase bits
	function automatic longint lfo_sine(input logic [PHASE_WIDTH-1:0] ph);
		logic [PHASE_WIDTH-1:0]     top;
		logic [1:0]                 quad;
		logic [SINE_TABLE_BITS-1:0] idx;
		longint                     s;
		top  = ph >> IDX_SHIFT;
		quad = top[SINE_TABLE_BITS+1 -: 2];
		idx  = top[SINE_TABLE_BITS-1:0];
		if (quad[0]) begin
			if (idx == 0)
				s = 32767;
			else
				s = sine_quarter[SINE_N - idx];
		end else begin
			s = sine_quarter[idx];
		end
		if (quad[1])
			s = -s;
		return s;
	endfunction

	// gain, scaling and saturation for one sample; advances the lfo phase
	function automatic tremolo_result_t tremolo_predict(input logic signed [SAMPLE_W-1:0] x_in);
		tremolo_result_t r;
		longint          xs, dep, term, gain, y;
		xs     = x_in;
		y      = xs;
		r.clip = 1'b0;
		if (cur_enable) begin
			dep  = cur_depth;
			term = (dep * lfo_sine(lfo_phase)) / 65536;
			gain = 32768 + term;
			y    = (xs * gain) / 32768;
			if (y > SAT_MAX) begin
				y      = SAT_MAX;
				r.clip = 1'b1;
			end else if (y < SAT_MIN) begin
				y      = SAT_MIN;
				r.clip = 1'b1;
			end
		end
		lfo_phase = lfo_phase + cur_phase_inc;
		r.sample  = y[SAMPLE_W-1:0];
		return r;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			tam_pkg::REG_PHASE_INC: cur_phase_inc = data;
			tam_pkg::REG_MOD_DEPTH: cur_depth = data[DEPTH_W-1:0];
			tam_pkg::REG_ENABLE:    cur_enable = data[0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTED)
			$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// one config transaction, then mirror it into the model
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_register(idx, data);
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || items_issued != items_taken
				|| expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		logic signed [SAMPLE_W-1:0] s;
		case ($urandom_range(0, 9))
			0: s = 32'sh7FFF_FFFF;
			1: s = 32'sh8000_0000;
			2: s = $signed($urandom_range(0, 511)) - 256;
			default: s = $urandom;
		endcase
		return s;
	endfunction

	// driver: one sample transaction at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			sample_in <= '0;
			send_gap  = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(tremolo_predict(sample_in));
				items_taken++;
			end
			if (in_valid && in_stall) begin
				// stalled payload stays put
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				in_valid  <= 1'b1;
				sample_in <= pending_samples.pop_front();
				items_issued++;
				if (!calm && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 16);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check results in order and drive the output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_gap = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result sample_out=%0d clipped=%0b",
						sample_out, clipped));
				end else begin
					want = expected_results.pop_front();
					if (sample_out !== want.sample)
						report_mismatch($sformatf("sample_out=%0d, expected %0d",
							sample_out, want.sample));
					if (clipped !== want.clip)
						report_mismatch($sformatf("clipped=%0b, expected %0b (sample %0d)",
							clipped, want.clip, want.sample));
				end
			end
			// long hold-off to back the block up, then random bursts
			if (hold_request && !hold_done && hold_left == 0)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0)
					hold_done = 1'b1;
				next_stall = 1'b1;
			end else if (stall_gap > 0) begin
				stall_gap--;
				next_stall = 1'b1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_gap  = $urandom_range(1, 16) - 1;
				next_stall = 1'b1;
			end else begin
				next_stall = 1'b0;
			end
			out_stall <= next_stall;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin : stimulus
		logic [31:0] inc_val;
		logic [31:0] cfg_word;
		int          phase_no;
		int          count;
		int          n;

		build_sine_quarter();
		cur_phase_inc = tam_pkg::PHASE_INC_RST;
		cur_depth     = tam_pkg::MOD_DEPTH_RST;
		cur_enable    = 1'b0;
		lfo_phase     = '0;
		phase_no      = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// quarter-cycle steps: every quadrant at index zero, full depth
		write_register(tam_pkg::REG_PHASE_INC, 32'h4000_0000);
		write_register(tam_pkg::REG_MOD_DEPTH, 32'hFFFF_FFFF);
		write_register(tam_pkg::REG_ENABLE, 32'h0000_0001);
		cfg_word = $urandom;
		write_register(REG_UNUSED, cfg_word);
		pending_samples.push_back(32'sh7FFF_FFFF);
		pending_samples.push_back(32'sh7FFF_FFFF);
		pending_samples.push_back(32'sh8000_0000);
		pending_samples.push_back(32'sh8000_0000);
		pending_samples.push_back(-32'sd1);
		pending_samples.push_back(32'sh8000_0000);
		pending_samples.push_back(32'sd1);
		pending_samples.push_back(32'sh7FFF_FFFF);
		pending_samples.push_back(32'sd0);
		pending_samples.push_back(-32'sd1);
		pending_samples.push_back(32'sh7FFF_FFFF);
		pending_samples.push_back(32'sh8000_0000);
		wait_drained();

		// wrapping increment with zero depth: unity gain
		write_register(tam_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
		write_register(tam_pkg::REG_MOD_DEPTH, 32'hABCD_0000);
		pending_samples.push_back(32'sh7FFF_FFFF);
		pending_samples.push_back(32'sh8000_0000);
		pending_samples.push_back(32'sh5555_5555);
		wait_drained();

		// pass-through, phase keeps running
		write_register(tam_pkg::REG_ENABLE, 32'hFFFF_FFFE);
		pending_samples.push_back(32'sh8000_0000);
		pending_samples.push_back(32'sh7FFF_FFFF);
		pending_samples.push_back(-32'sd1);
		pending_samples.push_back(32'sd0);
		pending_samples.push_back(32'shAAAA_AAAA);
		wait_drained();

		// random phases, each with its own register setting
		while (items_pushed < RANDOM_ITEMS) begin
			phase_no++;
			case ($urandom_range(0, 5))
				0: inc_val = 32'h0000_0000;
				1: inc_val = 32'hFFFF_FFFF;
				2: inc_val = 32'h8000_0000;
				3, 4: inc_val = $urandom_range(1, 1 << 22);
				default: inc_val = $urandom;
			endcase
			write_register(tam_pkg::REG_PHASE_INC, inc_val);
			cfg_word = $urandom;
			case ($urandom_range(0, 4))
				0: cfg_word[DEPTH_W-1:0] = '0;
				1: cfg_word[DEPTH_W-1:0] = '1;
				default: ;
			endcase
			write_register(tam_pkg::REG_MOD_DEPTH, cfg_word);
			cfg_word    = $urandom;
			cfg_word[0] = ($urandom_range(0, 3) != 0);
			write_register(tam_pkg::REG_ENABLE, cfg_word);
			if ($urandom_range(0, 7) == 0) begin
				cfg_word = $urandom;
				write_register(REG_UNUSED, cfg_word);
			end
			if (items_pushed > RANDOM_ITEMS * 7 / 8)
				calm = 1'b1;
			count = $urandom_range(20, 120);
			for (n = 0; n < count; n++)
				pending_samples.push_back(random_sample());
			items_pushed += count;
			if (phase_no == 3)
				hold_request = 1'b1;
			wait_drained();
		end

		wait_drained();
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/tam_pkg.sv
hdl/tam_ram.sv
hdl/tremolo_amplitude_modulator.sv
tb/tb_tremolo_amplitude_modulator.sv
